@@ rtl/core/rti_pkg.sv @@
`default_nettype none
package rti_pkg;

  // Fixed-point formats of the coordinates, directions and distance
  localparam int unsigned COORD_FRAC_BITS = 10;
  localparam int unsigned DIR_FRAC_BITS   = 16;
  localparam int unsigned DIST_FRAC_BITS  = 16;
  localparam int unsigned T_SHIFT = DIR_FRAC_BITS - COORD_FRAC_BITS + DIST_FRAC_BITS;

  localparam int unsigned COORD_W = 21;
  localparam int unsigned DIR_W   = 18;
  localparam int unsigned VERT_W  = 3 * COORD_W;
  localparam int unsigned IN_W    = 120;
  localparam int unsigned OUT_W   = 40;

  // Determinant magnitude width, numerator width and remainder width
  localparam int unsigned AM_W  = 62;
  localparam int unsigned NUM_W = 66 + T_SHIFT;
  localparam int unsigned LIM_W = 16 + AM_W;
  localparam int unsigned REM_W = AM_W + 32;

  // Pipeline: five arithmetic stages, then one stage per quotient bit
  localparam int unsigned PRE_STAGES = 5;
  localparam int unsigned QUOT_W     = 32;
  localparam int unsigned NUM_STAGES = PRE_STAGES + QUOT_W;

  typedef enum logic [2:0] {
    CFG_VERTEX_A     = 3'd0,
    CFG_VERTEX_B     = 3'd1,
    CFG_VERTEX_C     = 3'd2,
    CFG_PAR_EPSILON  = 3'd3,
    CFG_MIN_DISTANCE = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    REASON_HIT      = 3'd0,
    REASON_BACKFACE = 3'd1,
    REASON_PARALLEL = 3'd2,
    REASON_OUTSIDE  = 3'd3,
    REASON_BEHIND   = 3'd4
  } reason_e;

  // Payload carried through the quotient stages
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [AM_W-1:0]   am;
    logic [QUOT_W-1:0] quot;
    reason_e           reason;
    logic              sat;
  } div_t;

endpackage
`default_nettype wire

@@ rtl/core/rti_div_step.sv @@
`default_nettype none
module rti_div_step (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic [4:0]         bit_i,
  input  wire rti_pkg::div_t      data_i,
  output logic                    valid_o,
  output rti_pkg::div_t           data_o
);
  import rti_pkg::*;

  logic [REM_W-1:0] dv;
  div_t             data_d;
  div_t             data_q;
  logic             valid_q;

  // Restoring step: subtract the shifted divisor when it fits
  always_comb begin
    dv     = {{(REM_W-AM_W){1'b0}}, data_i.am} << bit_i;
    data_d = data_i;
    if (data_i.rem >= dv) begin
      data_d.rem          = data_i.rem - dv;
      data_d.quot[bit_i]  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

@@ rtl/core/ray_triangle_intersect.sv @@
`default_nettype none
// Pipeline: 5 arithmetic stages followed by 32 quotient stages.
// Throughput: one ray per cycle; each stage holds only while the stage after it is full
// and stalled, so the input keeps taking rays while a result waits, until all stages fill.
// The depth is set by the restoring divider for t, one quotient bit per stage.
// Reset clears all valid bits and loads the register reset values; no clearing pass.
module ray_triangle_intersect (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // configuration write port
  input  wire logic                      cfg_we_i,
  input  wire logic [2:0]                cfg_idx_i,
  input  wire logic [rti_pkg::VERT_W-1:0] cfg_wdata_i,
  // ray requests
  input  wire logic                      s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero pad
  input  wire logic [rti_pkg::IN_W-1:0]  s_axis_tdata_i,
  // results
  output logic                           m_axis_tvalid_o,
  input  wire logic                      m_axis_tready_i,
  // hit, miss_reason, hit_distance, zero pad
  output logic [rti_pkg::OUT_W-1:0]      m_axis_tdata_o
);
  import rti_pkg::*;

  // Configuration registers
  logic [VERT_W-1:0] va_q, vb_q, vc_q;
  logic [15:0]       eps_q, md_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q  <= '0;
      vb_q  <= '0;
      vc_q  <= '0;
      eps_q <= 16'd1;
      md_q  <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VERTEX_A:     va_q  <= cfg_wdata_i;
        CFG_VERTEX_B:     vb_q  <= cfg_wdata_i;
        CFG_VERTEX_C:     vc_q  <= cfg_wdata_i;
        CFG_PAR_EPSILON:  eps_q <= cfg_wdata_i[15:0];
        CFG_MIN_DISTANCE: md_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  logic signed [COORD_W-1:0] p0 [3];
  logic signed [COORD_W-1:0] p1 [3];
  logic signed [COORD_W-1:0] p2 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p0[i] = va_q[i*COORD_W +: COORD_W];
      p1[i] = vb_q[i*COORD_W +: COORD_W];
      p2[i] = vc_q[i*COORD_W +: COORD_W];
    end
  end

  // Triangle edges and normal, refreshed every cycle from the vertex registers
  logic signed [21:0] e1_q [3];
  logic signed [21:0] e2_q [3];
  logic signed [21:0] na_q [3];
  logic signed [21:0] nb_q [3];
  logic signed [45:0] n_q  [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= '0;
        e2_q[i] <= '0;
        na_q[i] <= '0;
        nb_q[i] <= '0;
        n_q[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= 22'(p1[i]) - 22'(p0[i]);
        e2_q[i] <= 22'(p2[i]) - 22'(p0[i]);
        na_q[i] <= 22'(p0[i]) - 22'(p1[i]);
        nb_q[i] <= 22'(p2[i]) - 22'(p1[i]);
      end
      n_q[0] <= na_q[1] * nb_q[2] - na_q[2] * nb_q[1];
      n_q[1] <= na_q[2] * nb_q[0] - na_q[0] * nb_q[2];
      n_q[2] <= na_q[0] * nb_q[1] - na_q[1] * nb_q[0];
    end
  end

  // Stage enables: a stage loads when it is empty or the stage after it moves
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES:0]   en;

  always_comb begin
    en[NUM_STAGES] = m_axis_tready_i;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end

  logic [PRE_STAGES-1:0] pre_vld_q;
  assign vld[PRE_STAGES-1:0] = pre_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= '0;
    end else begin
      if (en[0]) pre_vld_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k < PRE_STAGES; k++) begin
        if (en[k]) pre_vld_q[k] <= pre_vld_q[k-1];
      end
    end
  end

  assign s_axis_tready_o = en[0];

  // Stage A: capture the ray and offset the origin by the first vertex
  logic signed [DIR_W-1:0] a_d_q [3];
  logic signed [21:0]      a_s_q [3];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        a_d_q[i] <= s_axis_tdata_i[3*COORD_W + i*DIR_W +: DIR_W];
        a_s_q[i] <= 22'($signed(s_axis_tdata_i[i*COORD_W +: COORD_W])) - 22'(p0[i]);
      end
    end
  end

  // Stage B: cross products H = D x E2 and Q = S x E1
  logic signed [DIR_W-1:0] b_d_q [3];
  logic signed [21:0]      b_s_q [3];
  logic signed [40:0]      b_h_q [3];
  logic signed [44:0]      b_q_q [3];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      b_d_q    <= a_d_q;
      b_s_q    <= a_s_q;
      b_h_q[0] <= a_d_q[1] * e2_q[2] - a_d_q[2] * e2_q[1];
      b_h_q[1] <= a_d_q[2] * e2_q[0] - a_d_q[0] * e2_q[2];
      b_h_q[2] <= a_d_q[0] * e2_q[1] - a_d_q[1] * e2_q[0];
      b_q_q[0] <= a_s_q[1] * e1_q[2] - a_s_q[2] * e1_q[1];
      b_q_q[1] <= a_s_q[2] * e1_q[0] - a_s_q[0] * e1_q[2];
      b_q_q[2] <= a_s_q[0] * e1_q[1] - a_s_q[1] * e1_q[0];
    end
  end

  // Stage C: dot products for culling, determinant, barycentrics and t
  logic signed [63:0] c_nd_q, c_am_q, c_un_q, c_vn_q;
  logic signed [67:0] c_t_q;
  logic               c_nz_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      c_nz_q <= (n_q[0] != '0) || (n_q[1] != '0) || (n_q[2] != '0);
      c_nd_q <= n_q[0] * b_d_q[0] + n_q[1] * b_d_q[1] + n_q[2] * b_d_q[2];
      c_am_q <= -(e1_q[0] * b_h_q[0] + e1_q[1] * b_h_q[1] + e1_q[2] * b_h_q[2]);
      c_un_q <= -(b_s_q[0] * b_h_q[0] + b_s_q[1] * b_h_q[1] + b_s_q[2] * b_h_q[2]);
      c_vn_q <= -(b_d_q[0] * b_q_q[0] + b_d_q[1] * b_q_q[1] + b_d_q[2] * b_q_q[2]);
      c_t_q  <= -(e2_q[0] * b_q_q[0] + e2_q[1] * b_q_q[1] + e2_q[2] * b_q_q[2]);
    end
  end

  // Stage D: classify, scale t and form the minimum-distance bound
  reason_e            d_reason_d;
  logic signed [64:0] d_uv;
  reason_e            d_reason_q;
  logic [NUM_W-1:0]   d_num_q;
  logic [AM_W-1:0]    d_am_q;
  logic [LIM_W-1:0]   d_lim_q;

  always_comb begin
    d_uv = 65'(c_un_q) + 65'(c_vn_q);
    if (c_nz_q && !c_nd_q[63]) begin
      d_reason_d = REASON_BACKFACE;
    end else if (c_am_q[63] || (c_am_q == '0) || (c_am_q < $signed({48'd0, eps_q}))) begin
      d_reason_d = REASON_PARALLEL;
    end else if (c_un_q[63] || (c_un_q > c_am_q) || c_vn_q[63] || (d_uv > 65'(c_am_q))) begin
      d_reason_d = REASON_OUTSIDE;
    end else if (c_t_q[67] || (c_t_q == '0)) begin
      d_reason_d = REASON_BEHIND;
    end else begin
      d_reason_d = REASON_HIT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      d_reason_q <= d_reason_d;
      d_num_q    <= {c_t_q[65:0], {T_SHIFT{1'b0}}};
      d_am_q     <= c_am_q[AM_W-1:0];
      d_lim_q    <= md_q * c_am_q[AM_W-1:0];
    end
  end

  // Stage E: distance bound, saturation check, divider seed
  div_t e_d, e_q;

  always_comb begin
    e_d.rem    = {{(REM_W-NUM_W){1'b0}}, d_num_q};
    e_d.am     = d_am_q;
    e_d.quot   = '0;
    e_d.sat    = e_d.rem >= {d_am_q, {QUOT_W{1'b0}}};
    e_d.reason = d_reason_q;
    if ((d_reason_q == REASON_HIT) && ({{(NUM_W-LIM_W){1'b0}}, d_lim_q} >= d_num_q)) begin
      e_d.reason = REASON_BEHIND;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      e_q <= e_d;
    end
  end

  // Quotient stages, most significant bit first
  div_t div_data [QUOT_W+1];
  assign div_data[0] = e_q;

  for (genvar g = 0; g < QUOT_W; g++) begin : g_div
    rti_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[PRE_STAGES+g]),
      .valid_i (vld[PRE_STAGES+g-1]),
      .bit_i   (5'(QUOT_W - 1 - g)),
      .data_i  (div_data[g]),
      .valid_o (vld[PRE_STAGES+g]),
      .data_o  (div_data[g+1])
    );
  end

  // Result packing
  div_t        res;
  logic        res_hit;
  logic [31:0] res_dist;

  assign res      = div_data[QUOT_W];
  assign res_hit  = (res.reason == REASON_HIT);
  assign res_dist = !res_hit ? 32'd0 : (res.sat ? 32'hFFFF_FFFF : res.quot);

  assign m_axis_tvalid_o = vld[NUM_STAGES-1];
  assign m_axis_tdata_o  = {4'd0, res_dist, res.reason, res_hit};

endmodule
`default_nettype wire
